[hw/rtl/rfcef_pkg.sv]
// Package with shared types and constants of the RF remote code event filter.
package rfcef_pkg;
   localparam int KNOWN_DEVICES = 16;
   localparam int SEARCH_SLOTS = 16;
   localparam int TIME_BITS = 48;
   localparam int KIDX_BITS = (KNOWN_DEVICES > 1) ? $clog2(KNOWN_DEVICES) : 1;
   localparam int SIDX_BITS = (SEARCH_SLOTS > 1) ? $clog2(SEARCH_SLOTS) : 1;
   localparam int KCNT_BITS = $clog2(KNOWN_DEVICES + 1);
   localparam int SCNT_BITS = $clog2(SEARCH_SLOTS + 1);
   localparam logic [23:0] GAP_RESET = 24'd200000;

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_LOAD    = 2'd1,
      OP_START   = 2'd2,
      OP_END     = 2'd3
   } opcode_type;

   typedef struct packed {
      logic          known_hit;
      logic          sensor_event;
      logic          scan_event;
      logic          scan_full;
      logic [27:0]   event_serial;
      logic [3:0]    event_state;
      logic [15:0]   packet_total;
   } result_type;
endpackage

[hw/rtl/rfcef_known_table.sv]
// Known device table: serial, last time, packet count and state in one memory.
module rfcef_known_table
   import rfcef_pkg::*;
(
   input  logic                  clock,
   input  logic [KIDX_BITS-1:0]  rd_addr,
   output logic [27:0]           rd_serial,
   output logic [TIME_BITS-1:0]  rd_time,
   output logic [15:0]           rd_packets,
   input  logic                  wr_en,
   input  logic [KIDX_BITS-1:0]  wr_addr,
   input  logic [27:0]           wr_serial,
   input  logic [TIME_BITS-1:0]  wr_time,
   input  logic [15:0]           wr_packets,
   input  logic [3:0]            wr_state
);
   localparam int W = 28 + TIME_BITS + 16 + 4;
   logic [W-1:0] mem [KNOWN_DEVICES];
   logic [W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_serial, wr_time, wr_packets, wr_state};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_serial  = rd_ff[W-1 -: 28];
   assign rd_time    = rd_ff[W-29 -: TIME_BITS];
   assign rd_packets = rd_ff[19:4];
endmodule

[hw/rtl/rfcef_scan_table.sv]
// Scan table: serial, state and time of devices seen while searching.
module rfcef_scan_table
   import rfcef_pkg::*;
(
   input  logic                  clock,
   input  logic [SIDX_BITS-1:0]  rd_addr,
   output logic [27:0]           rd_serial,
   input  logic                  wr_en,
   input  logic [SIDX_BITS-1:0]  wr_addr,
   input  logic [27:0]           wr_serial,
   input  logic [3:0]            wr_state,
   input  logic [TIME_BITS-1:0]  wr_time
);
   localparam int W = 28 + 4 + TIME_BITS;
   logic [W-1:0] mem [SEARCH_SLOTS];
   logic [W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_serial, wr_state, wr_time};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_serial = rd_ff[W-1 -: 28];
endmodule

[hw/rtl/rf_remote_code_event_filter.sv]
// Top level of the RF remote code event filter with its sequencer.
// A receive word scans the known table serially, and also the scan table while searching.
// Load and start words go straight to the result; end search clears the scan table
// and stops searching.
// One word is in work at a time; the result register frees the input when taken.
// Reset clears both tables in a pass before the first word is accepted.
module rf_remote_code_event_filter
   import rfcef_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_opcode,
   input  logic [31:0]  req_code_word,
   input  logic [47:0]  req_timestamp_us,
   input  logic [3:0]   req_entry_index,
   input  logic [27:0]  req_entry_serial,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_known_hit,
   output logic         rsp_sensor_event,
   output logic         rsp_scan_event,
   output logic         rsp_scan_full,
   output logic [27:0]  rsp_event_serial,
   output logic [3:0]   rsp_event_state,
   output logic [15:0]  rsp_packet_total,
   input  logic         csr_write,
   input  logic [23:0]  csr_wdata
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_KSCAN, S_KUPD, S_SSCAN, S_SUPD, S_SCLEAR, S_DONE
   } state_type;

   localparam int CLR_MAX = (KNOWN_DEVICES > SEARCH_SLOTS) ? KNOWN_DEVICES : SEARCH_SLOTS;
   localparam int CBITS = $clog2(CLR_MAX + 1);

   state_type               state_ff, state_in;
   logic [CBITS-1:0]        cnt_ff, cnt_in;
   logic [23:0]             gap_ff;
   logic                    active_ff, active_in;
   opcode_type              op_ff;
   logic [27:0]             serial_ff;
   logic [3:0]              st_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [3:0]              eidx_ff;
   logic [27:0]             eser_ff;
   logic                    found_ff, found_in;
   logic [KIDX_BITS-1:0]    kidx_ff, kidx_in;
   logic [TIME_BITS-1:0]    klast_ff, klast_in;
   logic [15:0]             kpk_ff, kpk_in;
   logic [SIDX_BITS-1:0]    sidx_ff, sidx_in;
   logic [SCNT_BITS-1:0]    nz_ff, nz_in;
   result_type              res_ff, res_in;
   logic                    rv_ff, rv_in;

   logic [KIDX_BITS-1:0]    k_raddr, k_waddr;
   logic [27:0]             k_rserial, k_wserial;
   logic [TIME_BITS-1:0]    k_rtime, k_wtime;
   logic [15:0]             k_rpk, k_wpk;
   logic [3:0]              k_wstate;
   logic                    k_we;
   logic [SIDX_BITS-1:0]    s_raddr, s_waddr;
   logic [27:0]             s_rserial, s_wserial;
   logic [3:0]              s_wstate;
   logic [TIME_BITS-1:0]    s_wtime;
   logic                    s_we;
   logic [CBITS-1:0]        prev;
   logic [15:0]             pk_inc;
   logic                    accept;

   rfcef_known_table u_known (
      .clock(clock), .rd_addr(k_raddr), .rd_serial(k_rserial), .rd_time(k_rtime),
      .rd_packets(k_rpk), .wr_en(k_we), .wr_addr(k_waddr), .wr_serial(k_wserial),
      .wr_time(k_wtime), .wr_packets(k_wpk), .wr_state(k_wstate)
   );

   rfcef_scan_table u_scan (
      .clock(clock), .rd_addr(s_raddr), .rd_serial(s_rserial), .wr_en(s_we),
      .wr_addr(s_waddr), .wr_serial(s_wserial), .wr_state(s_wstate), .wr_time(s_wtime)
   );

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign accept = req_valid && req_ready;
   assign prev = cnt_ff - 1'b1;
   assign pk_inc = kpk_ff + 16'd1;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      active_in = active_ff;
      found_in = found_ff;
      kidx_in = kidx_ff;
      klast_in = klast_ff;
      kpk_in = kpk_ff;
      sidx_in = sidx_ff;
      nz_in = nz_ff;
      res_in = res_ff;
      rv_in = rv_ff;
      k_raddr = cnt_ff[KIDX_BITS-1:0];
      s_raddr = cnt_ff[SIDX_BITS-1:0];
      k_we = 1'b0;
      k_waddr = prev[KIDX_BITS-1:0];
      k_wserial = '0;
      k_wtime = '0;
      k_wpk = '0;
      k_wstate = '0;
      s_we = 1'b0;
      s_waddr = prev[SIDX_BITS-1:0];
      s_wserial = '0;
      s_wstate = '0;
      s_wtime = '0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            k_we = (prev < CBITS'(KNOWN_DEVICES)) && (cnt_ff != '0);
            s_we = (prev < CBITS'(SEARCH_SLOTS)) && (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CBITS'(CLR_MAX)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               found_in = 1'b0;
               nz_in = '0;
               state_in = S_DONE;
               if (opcode_type'(req_opcode) == OP_RECEIVE) begin
                  state_in = S_KSCAN;
               end else if (opcode_type'(req_opcode) == OP_END) begin
                  state_in = S_SCLEAR;
               end
            end
         end
         S_KSCAN: begin
            // Read address is cnt_ff; data of address prev arrives now.
            if (cnt_ff != '0 && !found_ff && k_rserial != '0 && k_rserial == serial_ff) begin
               found_in = 1'b1;
               kidx_in = prev[KIDX_BITS-1:0];
               klast_in = k_rtime;
               kpk_in = k_rpk;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CBITS'(KNOWN_DEVICES)) begin
               state_in = S_KUPD;
            end
         end
         S_KUPD: begin
            res_in = '0;
            res_in.event_serial = serial_ff;
            res_in.event_state = st_ff;
            if (found_ff) begin
               k_we = 1'b1;
               k_waddr = kidx_ff;
               k_wserial = serial_ff;
               k_wtime = now_ff;
               k_wpk = pk_inc;
               k_wstate = st_ff;
               res_in.known_hit = 1'b1;
               res_in.packet_total = pk_inc;
               res_in.sensor_event = (klast_ff != '0) && (now_ff >= klast_ff) &&
                  ((now_ff - klast_ff) > {{(TIME_BITS-24){1'b0}}, gap_ff});
            end
            cnt_in = '0;
            found_in = 1'b0;
            nz_in = '0;
            state_in = active_ff ? S_SSCAN : S_DONE;
         end
         S_SSCAN: begin
            if (cnt_ff != '0) begin
               if (s_rserial != '0) begin
                  nz_in = nz_ff + 1'b1;
               end
               if (!found_ff && s_rserial == serial_ff) begin
                  found_in = 1'b1;
                  sidx_in = prev[SIDX_BITS-1:0];
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CBITS'(SEARCH_SLOTS)) begin
               state_in = S_SUPD;
            end
         end
         S_SUPD: begin
            s_wserial = serial_ff;
            s_wstate = st_ff;
            s_wtime = now_ff;
            if (found_ff) begin
               s_we = 1'b1;
               s_waddr = sidx_ff;
               res_in.scan_event = 1'b1;
            end else if (nz_ff < SCNT_BITS'(SEARCH_SLOTS)) begin
               s_we = 1'b1;
               s_waddr = nz_ff[SIDX_BITS-1:0];
               res_in.scan_event = 1'b1;
            end else begin
               res_in.scan_full = 1'b1;
            end
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCLEAR: begin
            s_we = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CBITS'(SEARCH_SLOTS)) begin
               active_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (op_ff == OP_LOAD && {1'b0, eidx_ff} < 5'(KNOWN_DEVICES)) begin
               k_we = 1'b1;
               k_waddr = eidx_ff[KIDX_BITS-1:0];
               k_wserial = eser_ff;
            end
            if (op_ff == OP_START) begin
               active_in = 1'b1;
            end
            if (op_ff != OP_RECEIVE) begin
               res_in = '0;
            end
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         active_ff <= 1'b0;
         rv_ff <= 1'b0;
         gap_ff <= GAP_RESET;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         active_ff <= active_in;
         rv_ff <= rv_in;
         found_ff <= found_in;
         if (csr_write) begin
            gap_ff <= csr_wdata;
         end
      end
      kidx_ff <= kidx_in;
      klast_ff <= klast_in;
      kpk_ff <= kpk_in;
      sidx_ff <= sidx_in;
      nz_ff <= nz_in;
      res_ff <= res_in;
      if (accept) begin
         op_ff <= opcode_type'(req_opcode);
         serial_ff <= req_code_word[31:4];
         st_ff <= {req_code_word[0], req_code_word[1], req_code_word[2], req_code_word[3]};
         now_ff <= req_timestamp_us[TIME_BITS-1:0];
         eidx_ff <= req_entry_index;
         eser_ff <= req_entry_serial;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_known_hit = res_ff.known_hit;
   assign rsp_sensor_event = res_ff.sensor_event;
   assign rsp_scan_event = res_ff.scan_event;
   assign rsp_scan_full = res_ff.scan_full;
   assign rsp_event_serial = res_ff.event_serial;
   assign rsp_event_state = res_ff.event_state;
   assign rsp_packet_total = res_ff.packet_total;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_hit_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_known_hit |-> rsp_packet_total == '0 && !rsp_sensor_event)
      else $error("count without hit");
   a_scan_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_scan_event && rsp_scan_full)) else $error("scan event and full");
endmodule
